### design/msl_pkg.sv
// ----------------------------------------------------------------------------
// msl_pkg: shared types and constants of the multi-slot line receiver
// Slot geometry, operation codes, item and result structs, ring helpers.
// ----------------------------------------------------------------------------
package msl_pkg;

	// slot ring geometry
	localparam int NUM_SLOTS    = 3;
	localparam int BUFFER_BYTES = 64;
	localparam int SLOT_W       = 2;
	localparam int IDX_W        = 6;
	localparam int LEN_W        = 6;
	localparam int ADDR_W       = SLOT_W + IDX_W;
	localparam int STORE_DEPTH  = NUM_SLOTS * BUFFER_BYTES;

	// characters a slot may hold before bytes are dropped
	localparam logic [LEN_W-1:0] SLOT_LIMIT = LEN_W'(BUFFER_BYTES - 2);
	localparam logic [7:0]       CARRIAGE_RETURN = 8'h0d;

	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [LEN_W-1:0]  len_t;

	typedef enum logic [1:0] {
		OP_RECEIVE = 2'd0,
		OP_FETCH   = 2'd1,
		OP_READ    = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	// one accepted input transaction
	typedef struct packed {
		op_t              operation;
		logic [7:0]       rx_byte;
		slot_t            line_slot;
		logic [IDX_W-1:0] byte_index;
	} item_t;

	// per-transaction result from the slot logic
	typedef struct packed {
		logic  line_found;
		slot_t found_slot;
		len_t  line_length;
		logic  byte_dropped;
		logic  rd_hit;
	} res_t;

	// line store access request
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [7:0]        wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

	// next slot in the ring
	function automatic slot_t next_slot(slot_t s);
		return (s == SLOT_W'(NUM_SLOTS - 1)) ? '0 : s + 1'b1;
	endfunction

endpackage

### design/msl_chan_if.sv
// ----------------------------------------------------------------------------
// msl_chan_if: valid/ready channels of the multi-slot line receiver
// Input channel carries one operation, output channel carries one result.
// ----------------------------------------------------------------------------
interface msl_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] operation;
	logic [7:0] rx_byte;
	logic [1:0] line_slot;
	logic [5:0] byte_index;

	modport source (output valid, output operation, output rx_byte,
		output line_slot, output byte_index, input ready);
	modport sink (input valid, input operation, input rx_byte,
		input line_slot, input byte_index, output ready);
endinterface

interface msl_out_if;
	logic       valid;
	logic       ready;
	logic       line_found;
	logic [1:0] found_slot;
	logic [5:0] line_length;
	logic [7:0] read_byte;
	logic       byte_dropped;

	modport source (output valid, output line_found, output found_slot,
		output line_length, output read_byte, output byte_dropped, input ready);
	modport sink (input valid, input line_found, input found_slot,
		input line_length, input read_byte, input byte_dropped, output ready);
endinterface

### design/msl_ram.sv
// ----------------------------------------------------------------------------
// msl_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module msl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, holds when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### design/msl_slots.sv
// ----------------------------------------------------------------------------
// msl_slots: slot bookkeeping of the multi-slot line receiver
// Holds slot lengths, ready marks and ring pointers; does the rotating
// fetch search and forms the line store access for each transaction.
// ----------------------------------------------------------------------------
module msl_slots (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  msl_pkg::item_t    item,
	output msl_pkg::res_t     res,
	output msl_pkg::mem_req_t mem_req
);
	import msl_pkg::*;

	len_t  slot_length_q [NUM_SLOTS];
	logic  [NUM_SLOTS-1:0] slot_ready_q;
	slot_t fill_slot_q;
	slot_t fetch_start_q;

	logic  is_cr;
	logic  room;
	slot_t fill_next;
	logic  fetch_hit;
	slot_t fetch_pick;
	slot_t scan;
	logic  rd_slot_ok;
	slot_t rd_sel;

	// receive decode
	assign is_cr     = (item.rx_byte == CARRIAGE_RETURN);
	assign room      = (slot_length_q[fill_slot_q] < SLOT_LIMIT);
	assign fill_next = next_slot(fill_slot_q);

	// rotating priority search from the fetch pointer
	always_comb begin
		fetch_hit  = 1'b0;
		fetch_pick = '0;
		scan       = fetch_start_q;
		for (int n = 0; n < NUM_SLOTS; n++) begin
			if (!fetch_hit && slot_ready_q[scan]) begin
				fetch_hit  = 1'b1;
				fetch_pick = scan;
			end
			scan = next_slot(scan);
		end
	end

	// read range check
	assign rd_slot_ok = (item.line_slot < SLOT_W'(NUM_SLOTS));
	assign rd_sel     = rd_slot_ok ? item.line_slot : '0;

	// result fields
	always_comb begin
		res = '0;
		case (item.operation)
			OP_RECEIVE: begin
				res.byte_dropped = !is_cr && !room;
			end
			OP_FETCH: begin
				res.line_found  = fetch_hit;
				res.found_slot  = fetch_hit ? fetch_pick : '0;
				res.line_length = fetch_hit ? slot_length_q[fetch_pick] : '0;
			end
			OP_READ: begin
				res.rd_hit = rd_slot_ok &&
					(LEN_W'(item.byte_index) < slot_length_q[rd_sel]);
			end
			default: begin
				res = '0;
			end
		endcase
	end

	// line store access
	always_comb begin
		mem_req.we    = fire && (item.operation == OP_RECEIVE) && !is_cr && room;
		mem_req.waddr = {fill_slot_q, IDX_W'(slot_length_q[fill_slot_q])};
		mem_req.wdata = item.rx_byte;
		mem_req.re    = fire && res.rd_hit;
		mem_req.raddr = {rd_sel, item.byte_index};
	end

	// slot state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				slot_length_q[i] <= '0;
			end
			slot_ready_q  <= '0;
			fill_slot_q   <= '0;
			fetch_start_q <= '0;
		end else if (fire) begin
			case (item.operation)
				OP_RECEIVE: begin
					if (is_cr) begin
						slot_ready_q[fill_slot_q] <= 1'b1;
						slot_ready_q[fill_next]   <= 1'b0;
						slot_length_q[fill_next]  <= '0;
						fill_slot_q               <= fill_next;
					end else if (room) begin
						slot_length_q[fill_slot_q] <= slot_length_q[fill_slot_q] + 1'b1;
					end
				end
				OP_FETCH: begin
					if (fetch_hit) begin
						slot_ready_q[fetch_pick] <= 1'b0;
						fetch_start_q            <= next_slot(fetch_start_q);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// pointers stay inside the ring
	a_fill_in_ring: assert property (@(posedge clk) disable iff (!arst_n)
		fill_slot_q < SLOT_W'(NUM_SLOTS))
		else $error("fill slot out of ring");

	a_fetch_in_ring: assert property (@(posedge clk) disable iff (!arst_n)
		fetch_start_q < SLOT_W'(NUM_SLOTS))
		else $error("fetch pointer out of ring");

	// filling slot never exceeds its character limit
	a_fill_limit: assert property (@(posedge clk) disable iff (!arst_n)
		slot_length_q[fill_slot_q] <= SLOT_LIMIT)
		else $error("filling slot over limit");

	// a fetched line loses its ready mark and the pointer steps by one
	a_fetch_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (item.operation == OP_FETCH) && fetch_hit |=>
		!slot_ready_q[$past(fetch_pick)] &&
		(fetch_start_q == next_slot($past(fetch_start_q))))
		else $error("fetch did not retire the line");

	// store writes only for stored characters, reads only for hits
	a_mem_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_req.we && mem_req.re))
		else $error("line store written and read together");

endmodule

### design/multi_slot_line_receiver_top.sv
// ----------------------------------------------------------------------------
// multi_slot_line_receiver_top: line assembly over a ring of line slots
// Receives bytes into lines, fetches finished lines, reads stored bytes.
// ----------------------------------------------------------------------------
// Usage:
//   item   : valid/ready input channel; each transaction is one operation
//            (receive a byte, fetch the next finished line, read a byte).
//   result : valid/ready output channel; exactly one result transaction per
//            input transaction, in order.
//   A transaction is registered into the operation stage, where the slot
//   bookkeeping and the line store access happen; when that stage fires,
//   the result register takes its result, and the line store's registered
//   read data is loaded with it.
//   Throughput is one transaction per cycle while result.ready is high; the
//   operation stage and the result register form a two-deep pipeline, so a
//   new transaction is taken while a finished result waits.
//   When the receiver holds result.ready low, the result register holds and
//   the operation stage fills; item.ready then drops until the result moves.
//   Reset clears all slot lengths, ready marks and both ring pointers; the
//   line store itself is not cleared, no pass is needed since a byte is only
//   read below its slot's length.
// ----------------------------------------------------------------------------
module multi_slot_line_receiver_top (
	input  logic           clk,
	input  logic           arst_n,
	msl_in_if.sink         item,
	msl_out_if.source      result
);
	import msl_pkg::*;

	logic     valid_s1;
	item_t    item_s1;
	logic     valid_s2;
	res_t     res_s2;
	logic     fire_s1;
	logic     take;
	res_t     res;
	mem_req_t mem_req;
	logic [7:0] rdata;

	// pipeline advance
	assign fire_s1    = valid_s1 && (!valid_s2 || result.ready);
	assign item.ready = !valid_s1 || fire_s1;
	assign take       = item.valid && item.ready;

	// operation stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// operation stage payload
	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.operation  <= op_t'(item.operation);
			item_s1.rx_byte    <= item.rx_byte;
			item_s1.line_slot  <= item.line_slot;
			item_s1.byte_index <= item.byte_index;
		end
	end

	// slot bookkeeping
	msl_slots u_slots (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire_s1),
		.item    (item_s1),
		.res     (res),
		.mem_req (mem_req)
	);

	// line store
	msl_ram #(
		.WIDTH (8),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.re    (mem_req.re),
		.raddr (mem_req.raddr),
		.rdata (rdata)
	);

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fire_s1) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (fire_s1) begin
			res_s2 <= res;
		end
	end

	// output channel
	assign result.valid        = valid_s2;
	assign result.line_found   = res_s2.line_found;
	assign result.found_slot   = res_s2.found_slot;
	assign result.line_length  = res_s2.line_length;
	assign result.byte_dropped = res_s2.byte_dropped;
	assign result.read_byte    = res_s2.rd_hit ? rdata : 8'h00;

endmodule
